>>> rtl/cfwp_pkg.sv
`timescale 1ns / 1ps
package cfwp_pkg;

	localparam logic [31:0] PKT_MAGIC   = 32'h5734_3844;
	localparam logic [31:0] PKT_VERSION = 32'h0070_0101;
	localparam logic [31:0] CRC_POLY    = 32'hedb8_8320;
	localparam logic [31:0] CRC_ALL     = 32'hffff_ffff;
	localparam logic [31:0] STD_ID_MAX  = 32'h0000_07ff;
	localparam logic [31:0] EXT_ID_MAX  = 32'h1fff_ffff;
	localparam logic [4:0]  AREA_WORDS  = 5'd18;
	localparam logic [3:0]  HDR_LAST    = 4'd8;
	localparam int unsigned Q_DEPTH     = 2;
	localparam int unsigned Q_PTR_W     = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W     = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic        command;
		logic [31:0] can_id;
		logic [7:0]  bus_channel;
		logic        is_extended;
		logic        is_fd;
		logic        bit_rate_switch;
		logic        is_remote;
		logic [7:0]  length_code;
		logic [7:0]  byte_count;
		logic [63:0] time_us;
		logic [31:0] seq_number;
		logic [31:0] payload_word;
	} cfwp_req_t;

	typedef struct packed {
		logic [31:0] packet_word;
		logic        rejected;
		logic        last_word;
	} cfwp_pkt_t;

	typedef enum logic [1:0] {
		K_REJECT,
		K_HEADER,
		K_DATA
	} cmd_kind_t;

	// For a header, close marks a frame with no payload; for data, the last payload word.
	typedef struct packed {
		cmd_kind_t   kind;
		logic        close;
		logic [31:0] data;
		logic [31:0] seq;
		logic [63:0] stamp;
		logic [31:0] id;
		logic [31:0] info;
	} cfwp_cmd_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_HDR,
		B_PAD,
		B_CRC
	} back_state_t;

	function automatic logic [7:0] dlc_bytes(input logic [3:0] dlc);
		logic [7:0] r;
		case (dlc)
			4'd9:    r = 8'd12;
			4'd10:   r = 8'd16;
			4'd11:   r = 8'd20;
			4'd12:   r = 8'd24;
			4'd13:   r = 8'd32;
			4'd14:   r = 8'd48;
			4'd15:   r = 8'd64;
			default: r = {4'd0, dlc};
		endcase
		return r;
	endfunction

	// Effect of one input bit on the register after 32 reflected shift steps.
	function automatic logic [31:0] crc_col(input int unsigned bit_idx);
		logic [31:0] c;
		c = 32'd1 << bit_idx;
		for (int k = 0; k < 32; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

>>> rtl/cfwp_front.sv
`timescale 1ns / 1ps
module cfwp_front
	import cfwp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  cfwp_req_t   req,
	input  logic [63:0] session,
	input  logic        q_full,
	output logic        q_push,
	output cfwp_cmd_t   q_cmd
);

	logic       open_q;
	logic [6:0] bytes_q;
	logic       open_n;
	logic [6:0] bytes_n;
	logic       bad;
	logic [31:0] mask;
	logic [6:0] take;
	logic       accept;

	assign req_ready = !q_full;
	assign accept    = req_valid && req_ready;

	always_comb begin
		bad = (session == 64'd0) || req.is_remote || (req.bus_channel >= 8'd2) ||
		      (req.can_id > (req.is_extended ? EXT_ID_MAX : STD_ID_MAX)) ||
		      (!req.is_fd && (req.bit_rate_switch || (req.length_code > 8'd8))) ||
		      (req.length_code > 8'd15) ||
		      (req.byte_count != dlc_bytes(req.length_code[3:0]));
		case (bytes_q)
			7'd0:    mask = 32'h0000_0000;
			7'd1:    mask = 32'h0000_00ff;
			7'd2:    mask = 32'h0000_ffff;
			7'd3:    mask = 32'h00ff_ffff;
			default: mask = 32'hffff_ffff;
		endcase
		take = (bytes_q < 7'd4) ? bytes_q : 7'd4;

		q_push = 1'b0;
		open_n = open_q;
		bytes_n = bytes_q;
		q_cmd.kind  = K_REJECT;
		q_cmd.close = 1'b0;
		q_cmd.data  = req.payload_word & mask;
		q_cmd.seq   = req.seq_number;
		q_cmd.stamp = req.time_us;
		q_cmd.id    = req.can_id;
		q_cmd.info  = {req.byte_count, req.length_code, 5'd0, req.bit_rate_switch,
		               req.is_fd, req.is_extended, req.bus_channel};

		if (accept) begin
			if (!req.command) begin
				q_push = 1'b1;
				if (bad) begin
					q_cmd.kind = K_REJECT;
					open_n = 1'b0;
					bytes_n = 7'd0;
				end else begin
					q_cmd.kind  = K_HEADER;
					q_cmd.close = (req.byte_count == 8'd0);
					open_n  = (req.byte_count != 8'd0);
					bytes_n = req.byte_count[6:0];
				end
			end else if (open_q) begin
				q_push = 1'b1;
				q_cmd.kind  = K_DATA;
				bytes_n     = bytes_q - take;
				q_cmd.close = (bytes_n == 7'd0);
				open_n      = (bytes_n != 7'd0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			bytes_q <= 7'd0;
		end else begin
			open_q  <= open_n;
			bytes_q <= bytes_n;
		end
	end

endmodule

>>> rtl/cfwp_queue.sv
`timescale 1ns / 1ps
module cfwp_queue
	import cfwp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cfwp_cmd_t push_cmd,
	input  logic      pop,
	output logic      full,
	output logic      head_valid,
	output cfwp_cmd_t head
);

	cfwp_cmd_t            slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_q;
	logic [Q_PTR_W-1:0]   rd_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 do_pop;

	assign full       = (count_q == Q_CNT_W'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			count_q <= count_q + Q_CNT_W'(push) - Q_CNT_W'(do_pop);
		end
	end

endmodule

>>> rtl/cfwp_back.sv
`timescale 1ns / 1ps
module cfwp_back
	import cfwp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] session,
	input  logic        q_valid,
	input  cfwp_cmd_t   q_cmd,
	output logic        q_pop,
	output logic        pkt_valid,
	input  logic        pkt_ready,
	output cfwp_pkt_t   pkt
);

	back_state_t state_q, state_n;
	logic [3:0]  idx_q, idx_n;
	logic [4:0]  area_q, area_n;
	logic [31:0] crc_q, crc_n;
	cfwp_cmd_t   hdr_q;
	logic        hdr_load;
	logic        out_valid_q;
	cfwp_pkt_t   out_q;
	logic        slot_free;
	logic        emit;
	logic        upd;
	logic        crc_init;
	cfwp_pkt_t   word;
	logic [31:0] crc_mix;
	logic [31:0] crc_next;
	logic [31:0] col_term [32];
	logic [31:0] hdr_word;

	assign slot_free = !out_valid_q || pkt_ready;
	assign pkt_valid = out_valid_q;
	assign pkt       = out_q;

	assign crc_mix = (crc_init ? CRC_ALL : crc_q) ^ word.packet_word;

	for (genvar g = 0; g < 32; g++) begin : g_col
		localparam logic [31:0] COL = crc_col(g);
		assign col_term[g] = crc_mix[g] ? COL : 32'd0;
	end

	always_comb begin
		crc_next = 32'd0;
		for (int i = 0; i < 32; i++) begin
			crc_next = crc_next ^ col_term[i];
		end
	end

	always_comb begin
		case (idx_q)
			4'd1:    hdr_word = PKT_VERSION;
			4'd2:    hdr_word = session[31:0];
			4'd3:    hdr_word = session[63:32];
			4'd4:    hdr_word = hdr_q.seq;
			4'd5:    hdr_word = hdr_q.stamp[31:0];
			4'd6:    hdr_word = hdr_q.stamp[63:32];
			4'd7:    hdr_word = hdr_q.id;
			4'd8:    hdr_word = hdr_q.info;
			default: hdr_word = PKT_MAGIC;
		endcase
	end

	always_comb begin
		state_n  = state_q;
		idx_n    = idx_q;
		area_n   = area_q;
		q_pop    = 1'b0;
		emit     = 1'b0;
		upd      = 1'b0;
		crc_init = 1'b0;
		hdr_load = 1'b0;
		word     = '{packet_word: 32'd0, rejected: 1'b0, last_word: 1'b0};
		case (state_q)
			B_IDLE: begin
				if (slot_free && q_valid) begin
					q_pop = 1'b1;
					case (q_cmd.kind)
						K_REJECT: begin
							emit = 1'b1;
							word.rejected  = 1'b1;
							word.last_word = 1'b1;
						end
						K_HEADER: begin
							emit     = 1'b1;
							upd      = 1'b1;
							crc_init = 1'b1;
							hdr_load = 1'b1;
							word.packet_word = PKT_MAGIC;
							idx_n   = 4'd1;
							area_n  = AREA_WORDS;
							state_n = B_HDR;
						end
						K_DATA: begin
							emit = 1'b1;
							upd  = 1'b1;
							word.packet_word = q_cmd.data;
							area_n = area_q - 5'd1;
							if (q_cmd.close) begin
								state_n = (area_n == 5'd0) ? B_CRC : B_PAD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			B_HDR: begin
				if (slot_free) begin
					emit = 1'b1;
					upd  = 1'b1;
					word.packet_word = hdr_word;
					idx_n = idx_q + 4'd1;
					if (idx_q == HDR_LAST) begin
						state_n = hdr_q.close ? B_PAD : B_IDLE;
					end
				end
			end
			B_PAD: begin
				if (slot_free) begin
					emit = 1'b1;
					upd  = 1'b1;
					area_n = area_q - 5'd1;
					if (area_q == 5'd1) begin
						state_n = B_CRC;
					end
				end
			end
			B_CRC: begin
				if (slot_free) begin
					emit = 1'b1;
					word.packet_word = crc_q ^ CRC_ALL;
					word.last_word   = 1'b1;
					state_n = B_IDLE;
				end
			end
			default: begin
				state_n = B_IDLE;
			end
		endcase
		if (upd) begin
			crc_n = crc_next;
		end else if (state_q == B_CRC && emit) begin
			crc_n = CRC_ALL;
		end else begin
			crc_n = crc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_load) begin
			hdr_q <= q_cmd;
		end
		if (slot_free) begin
			out_q <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= 4'd0;
			area_q      <= 5'd0;
			crc_q       <= CRC_ALL;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			idx_q   <= idx_n;
			area_q  <= area_n;
			crc_q   <= crc_n;
			if (slot_free) begin
				out_valid_q <= emit;
			end
		end
	end

endmodule

>>> rtl/can_frame_wire_packer.sv
`timescale 1ns / 1ps
// Checks CAN and CAN FD frame descriptors and packs each good frame into a 112-byte packet that
// leaves as 28 little-endian words ending in a reflected CRC-32 word, while a bad descriptor gives
// a single rejected word. Input words are taken one per cycle while the two-entry command queue
// has room, and packet words leave one per cycle while pkt_ready is high, so the output port sets
// the rate: a frame of up to 17 input words gives 28 packet words. The session number is written
// over the APB port at byte address 0 and must be nonzero for frames to pass.
module can_frame_wire_packer
	import cfwp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_ready,
	input  cfwp_req_t   req,
	output logic        pkt_valid,
	input  logic        pkt_ready,
	output cfwp_pkt_t   pkt
);

	logic [63:0] session_q;
	logic        q_full;
	logic        q_push;
	cfwp_cmd_t   q_push_cmd;
	logic        q_pop;
	logic        q_valid;
	cfwp_cmd_t   q_head;

	assign pready = 1'b1;
	assign prdata = paddr[3] ? 64'd0 : session_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_q <= 64'd0;
		end else if (psel && penable && pwrite && pready && !paddr[3]) begin
			session_q <= pwdata;
		end
	end

	cfwp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.session   (session_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_push_cmd)
	);

	cfwp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_push_cmd),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head       (q_head)
	);

	cfwp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.session   (session_q),
		.q_valid   (q_valid),
		.q_cmd     (q_head),
		.q_pop     (q_pop),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt)
	);

endmodule

>>> bench/can_frame_wire_packer_test.sv
`timescale 1ns / 1ps
module can_frame_wire_packer_test;
	import cfwp_pkg::*;

	localparam logic       CMD_DESC     = 1'b0;
	localparam logic       CMD_PAYLOAD  = 1'b1;
	localparam logic [3:0] ADDR_SESSION = 4'd0;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         DRAIN_CYCLES = 40;
	localparam int         HOLD_CYCLES  = 600;
	localparam int         RANDOM_ITEMS = 300;

	function automatic logic [7:0] dlc_length(input logic [3:0] dlc);
		int d;
		d = int'(dlc);
		if (d <= 8) begin
			return 8'(d);
		end else if (d <= 12) begin
			return 8'(4 * (d - 6));
		end
		return 8'(16 * (d - 11));
	endfunction

	class frame_packer_model;
		logic [63:0] session;
		logic [31:0] crc;
		logic        frame_open;
		logic [4:0]  words_left;
		logic [6:0]  bytes_left;
		cfwp_pkt_t   due_words[$];
		int          mismatches;

		function new();
			session    = '0;
			crc        = CRC_ALL;
			frame_open = 1'b0;
			words_left = '0;
			bytes_left = '0;
			mismatches = 0;
		endfunction

		function void push_word(logic [31:0] w, logic rej, logic last);
			cfwp_pkt_t p;
			p.packet_word = w;
			p.rejected    = rej;
			p.last_word   = last;
			due_words.push_back(p);
		endfunction

		function void push_data(logic [31:0] w);
			logic fb;
			for (int i = 0; i < 32; i++) begin
				fb  = crc[0] ^ w[i];
				crc = crc >> 1;
				if (fb) begin
					crc = crc ^ CRC_POLY;
				end
			end
			push_word(w, 1'b0, 1'b0);
		endfunction

		function void close_packet();
			while (words_left > 0) begin
				push_data(32'd0);
				words_left--;
			end
			push_word(crc ^ CRC_ALL, 1'b0, 1'b1);
			frame_open = 1'b0;
			bytes_left = '0;
			crc        = CRC_ALL;
		endfunction

		function void accept_request(cfwp_req_t r);
			logic        bad;
			logic [31:0] id_max;
			logic [31:0] w;
			int          take;
			if (r.command == CMD_DESC) begin
				frame_open = 1'b0;
				bytes_left = '0;
				words_left = '0;
				crc        = CRC_ALL;
				id_max = r.is_extended ? EXT_ID_MAX : STD_ID_MAX;
				bad = session == 64'd0 || r.is_remote || r.bus_channel >= 8'd2 ||
					r.can_id > id_max ||
					(!r.is_fd && (r.bit_rate_switch || r.length_code > 8'd8)) ||
					r.length_code > 8'd15 ||
					r.byte_count != dlc_length(r.length_code[3:0]);
				if (bad) begin
					push_word(32'd0, 1'b1, 1'b1);
				end else begin
					push_data(PKT_MAGIC);
					push_data(PKT_VERSION);
					push_data(session[31:0]);
					push_data(session[63:32]);
					push_data(r.seq_number);
					push_data(r.time_us[31:0]);
					push_data(r.time_us[63:32]);
					push_data(r.can_id);
					push_data({r.byte_count, r.length_code, 5'd0, r.bit_rate_switch,
						r.is_fd, r.is_extended, r.bus_channel});
					words_left = AREA_WORDS;
					bytes_left = r.byte_count[6:0];
					frame_open = 1'b1;
					if (bytes_left == 0) begin
						close_packet();
					end
				end
			end else if (frame_open) begin
				take = (bytes_left < 4) ? int'(bytes_left) : 4;
				w = r.payload_word;
				if (take < 4) begin
					w = w & ((32'd1 << (8 * take)) - 32'd1);
				end
				push_data(w);
				bytes_left = bytes_left - 7'(take);
				if (words_left > 0) begin
					words_left--;
				end
				if (bytes_left == 0 || words_left == 0) begin
					close_packet();
				end
			end
		endfunction

		function void check_word(cfwp_pkt_t got);
			cfwp_pkt_t want;
			if (due_words.size() == 0) begin
				$error("packet word %h arrived with no word due", got.packet_word);
				mismatches++;
			end else begin
				want = due_words.pop_front();
				if (got.packet_word !== want.packet_word) begin
					$error("packet_word: expected %h, actual %h", want.packet_word,
						got.packet_word);
					mismatches++;
				end
				if (got.rejected !== want.rejected) begin
					$error("rejected: expected %b, actual %b", want.rejected, got.rejected);
					mismatches++;
				end
				if (got.last_word !== want.last_word) begin
					$error("last_word: expected %b, actual %b", want.last_word, got.last_word);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        req_valid;
	logic        req_ready;
	cfwp_req_t   req;
	logic        pkt_valid;
	logic        pkt_ready;
	cfwp_pkt_t   pkt;

	frame_packer_model model;
	int                burst_left;
	logic              hold_request;

	can_frame_wire_packer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) begin
			model.accept_request(req);
		end
		if (arst_n && pkt_valid && pkt_ready) begin
			model.check_word(pkt);
		end
	end

	initial begin
		int stretch_left;
		int mode;
		pkt_ready    = 1'b0;
		stretch_left = 0;
		mode         = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				pkt_ready    = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				if (stretch_left == 0) begin
					mode         = $urandom_range(0, 2);
					stretch_left = $urandom_range(5, 60);
				end
				stretch_left--;
				case (mode)
					0: pkt_ready = 1'b1;
					1: pkt_ready = ($urandom_range(0, 9) < 7);
					default: pkt_ready = ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("can_frame_wire_packer test failed");
		$finish;
	end

	function automatic cfwp_req_t noise_req();
		cfwp_req_t r;
		r.command         = 1'($urandom_range(0, 1));
		r.can_id          = $urandom;
		r.bus_channel     = 8'($urandom);
		r.is_extended     = 1'($urandom_range(0, 1));
		r.is_fd           = 1'($urandom_range(0, 1));
		r.bit_rate_switch = 1'($urandom_range(0, 1));
		r.is_remote       = 1'($urandom_range(0, 1));
		r.length_code     = 8'($urandom);
		r.byte_count      = 8'($urandom);
		r.time_us         = {$urandom, $urandom};
		r.seq_number      = $urandom;
		r.payload_word    = $urandom;
		return r;
	endfunction

	function automatic cfwp_req_t desc_of(logic [31:0] id, logic [7:0] chan, logic ext,
		logic fd, logic brs, logic [7:0] dlc, logic [7:0] len);
		cfwp_req_t r;
		r = noise_req();
		r.command         = CMD_DESC;
		r.can_id          = id;
		r.bus_channel     = chan;
		r.is_extended     = ext;
		r.is_fd           = fd;
		r.bit_rate_switch = brs;
		r.is_remote       = 1'b0;
		r.length_code     = dlc;
		r.byte_count      = len;
		return r;
	endfunction

	function automatic cfwp_req_t good_desc();
		cfwp_req_t   r;
		logic [31:0] id_max;
		logic        ext;
		logic        fd;
		logic [7:0]  dlc;
		ext = 1'($urandom_range(0, 1));
		fd  = 1'($urandom_range(0, 1));
		id_max = ext ? EXT_ID_MAX : STD_ID_MAX;
		if (fd && $urandom_range(0, 3) == 0) begin
			dlc = 8'($urandom_range(9, 15));
		end else begin
			dlc = 8'($urandom_range(0, 8));
		end
		r = desc_of($urandom & id_max, 8'($urandom_range(0, 1)), ext, fd,
			fd & 1'($urandom_range(0, 1)), dlc, dlc_length(dlc[3:0]));
		if ($urandom_range(0, 7) == 0) begin
			r.can_id = id_max;
		end
		return r;
	endfunction

	task automatic send_item(input cfwp_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		req       = r;
		req_valid = 1'b1;
		burst_left--;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	task automatic send_payload(input int count);
		cfwp_req_t r;
		for (int i = 0; i < count; i++) begin
			r = noise_req();
			r.command = CMD_PAYLOAD;
			send_item(r);
		end
	endtask

	task automatic finish_phase();
		cfwp_req_t r;
		r = good_desc();
		r.is_remote = 1'b1;
		send_item(r);
		req_valid = 1'b0;
		while (model.due_words.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_session(input logic [63:0] value);
		logic [63:0] readback;
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_SESSION;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (readback !== value) begin
			$error("session_id: expected %h, actual %h", value, readback);
			model.mismatches++;
		end
		model.session = value;
	endtask

	task automatic random_traffic(input int count);
		cfwp_req_t   r;
		int          sent;
		int          pick;
		int          words;
		int          twist;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				r = good_desc();
				send_item(r);
				words = (int'(r.byte_count) + 3) / 4;
				twist = $urandom_range(0, 9);
				if (twist == 0) begin
					words = $urandom_range(0, words);
				end else if (twist == 1) begin
					words = words + $urandom_range(1, 3);
				end
				send_payload(words);
				sent = sent + 1 + words;
			end else if (pick < 80) begin
				r = noise_req();
				r.command = CMD_DESC;
				send_item(r);
				sent++;
			end else if (pick < 93) begin
				r = good_desc();
				case ($urandom_range(0, 5))
					0: r.is_remote = 1'b1;
					1: r.bus_channel = 8'($urandom_range(2, 255));
					2: r.can_id = r.is_extended ? (32'h2000_0000 | $urandom)
						: (32'h0000_0800 | $urandom);
					3: begin
						r.is_fd           = 1'b0;
						r.bit_rate_switch = 1'b1;
					end
					4: r.byte_count = r.byte_count ^ (8'd1 << $urandom_range(0, 7));
					default: r.length_code = 8'($urandom_range(16, 255));
				endcase
				send_item(r);
				sent++;
				if ($urandom_range(0, 3) == 0) begin
					send_payload($urandom_range(1, 2));
				end
			end else begin
				send_payload($urandom_range(1, 3));
			end
		end
	endtask

	initial begin
		cfwp_req_t r;
		model        = new();
		burst_left   = 0;
		hold_request = 1'b0;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		req_valid    = 1'b0;
		req          = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(good_desc());
		send_item(good_desc());
		finish_phase();
		set_session('1);

		send_item(desc_of(STD_ID_MAX, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0));
		r = desc_of(EXT_ID_MAX, 8'd1, 1'b1, 1'b1, 1'b1, 8'd13, 8'd32);
		r.time_us    = '1;
		r.seq_number = '1;
		send_item(r);
		send_payload(8);
		r = desc_of(32'd0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd3, 8'd3);
		r.time_us    = '0;
		r.seq_number = '0;
		send_item(r);
		r = noise_req();
		r.command      = CMD_PAYLOAD;
		r.payload_word = '1;
		send_item(r);
		send_item(desc_of(32'h123, 8'd1, 1'b0, 1'b1, 1'b0, 8'd9, 8'd12));
		send_payload(1);
		r = desc_of(32'h5, 8'd0, 1'b0, 1'b0, 1'b0, 8'd5, 8'd5);
		r.is_remote = 1'b1;
		send_item(r);
		send_payload(1);
		send_item(desc_of(32'd1, 8'd2, 1'b0, 1'b0, 1'b0, 8'd1, 8'd1));
		send_item(desc_of(32'h800, 8'd0, 1'b0, 1'b0, 1'b0, 8'd1, 8'd1));
		send_item(desc_of(32'h2000_0000, 8'd0, 1'b1, 1'b1, 1'b0, 8'd1, 8'd1));
		send_item(desc_of(32'd1, 8'd0, 1'b0, 1'b0, 1'b1, 8'd1, 8'd1));
		send_item(desc_of(32'd1, 8'd0, 1'b0, 1'b0, 1'b0, 8'd9, 8'd12));
		send_item(desc_of(32'd1, 8'd0, 1'b0, 1'b1, 1'b0, 8'd16, 8'd0));
		send_item(desc_of(32'd1, 8'd0, 1'b0, 1'b1, 1'b0, 8'd2, 8'd3));
		finish_phase();

		set_session(64'd1);
		hold_request = 1'b1;
		random_traffic(RANDOM_ITEMS / 2);
		finish_phase();

		set_session({$urandom, $urandom});
		random_traffic(RANDOM_ITEMS / 2);
		finish_phase();

		set_session(64'd0);
		send_item(good_desc());
		send_item(good_desc());
		send_payload(1);
		finish_phase();

		if (model.mismatches == 0) begin
			$display("can_frame_wire_packer test passed");
		end else begin
			$display("can_frame_wire_packer test failed");
		end
		$finish;
	end

endmodule
